// File: rtl/assert_macros.svh
// Assertion macro used by the checker file.
// Depends on nothing; the macro takes a label, a clock, a reset and a property.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`endif

// File: rtl/sdspi_pkg.sv
// Package for the SD SPI command engine: payload structs, phase codes, constants.
// Used by the sequencer, the top level, the checker and the bench; depends on nothing.
package sdspi_pkg;

   typedef struct packed {
      logic        func;
      logic [5:0]  cmd_index;
      logic [31:0] cmd_arg;
      logic [7:0]  cmd_crc;
      logic [2:0]  resp_len;
      logic        block_read;
      logic [7:0]  rx_byte;
   } req_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       cs_active;
      logic       data_valid;
      logic [7:0] data_byte;
      logic       r1_valid;
      logic [7:0] r1_code;
      logic       done_res;
      logic [1:0] status;
   } rsp_type;

   typedef enum logic [3:0] {
      PH_IDLE, PH_DUMMY, PH_CMD, PH_POLL, PH_RESP, PH_TOKEN, PH_BLOCK, PH_POST
   } phase_type;

   localparam logic       FUNC_START   = 1'b0;
   localparam logic [7:0] BYTE_IDLE    = 8'hFF;
   localparam logic [7:0] BYTE_TOKEN   = 8'hFE;
   localparam logic [7:0] CMD_PREFIX   = 8'h40;
   localparam logic [7:0] CRC_STOP     = 8'h01;
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_CARD_ERR  = 2'd1;
   localparam logic [1:0] ST_TIMEOUT   = 2'd2;
   localparam int         CSR_POST_LEN = 0;
   localparam int         CSR_POLL_LIM = 1;

endpackage

// File: rtl/sdspi_queue.sv
// Two-entry queue of packed items used between the parts of the engine.
// Depends on nothing but its width parameter.
module sdspi_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   logic [WIDTH-1:0] slot_ff [2];
   logic [1:0]       count_ff, count_in;
   logic             rd_ff, rd_in, wr_ff, wr_in;
   logic             do_push, do_pop;

   assign full     = count_ff == 2'd2;
   assign empty    = count_ff == 2'd0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ff];

   // Pointer and fill count update.
   always_comb begin
      count_in = count_ff + 2'(do_push) - 2'(do_pop);
      rd_in    = rd_ff ^ do_pop;
      wr_in    = wr_ff ^ do_push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rd_ff    <= 1'b0;
         wr_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_data;
   end
endmodule

// File: rtl/sdspi_sequencer.sv
// Back part of the engine: the command phase machine, one item per cycle while out_ready is high.
// Depends on sdspi_pkg for the payload structs, phase codes and constants.
module sdspi_sequencer #(
   parameter int BLOCK_BYTES = 512
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  sdspi_pkg::req_type in_item,
   output logic             out_valid,
   input  logic             out_ready,
   output sdspi_pkg::rsp_type out_item,
   input  logic [7:0]       post_len,
   input  logic [15:0]      poll_limit
);
   import sdspi_pkg::*;

   localparam logic [9:0] BLOCK_LAST = 10'(BLOCK_BYTES - 1);

   phase_type   phase_ff, phase_in;
   logic [9:0]  count_ff, count_in;
   logic [15:0] poll_ff, poll_in, poll_inc;
   logic [31:0] arg_ff;
   logic [5:0]  cmd_ff;
   logic [7:0]  crc_ff;
   logic [2:0]  rlen_ff;
   logic        blk_ff;
   logic [1:0]  stat_ff, stat_in;
   logic        take;
   logic [7:0]  rx, cbyte;
   logic [2:0]  cidx;
   rsp_type     res;

   assign in_ready  = out_ready;
   assign out_valid = in_valid;
   assign out_item  = res;
   assign take      = in_valid && out_ready;
   assign rx        = in_item.rx_byte;
   assign poll_inc  = poll_ff + 16'd1;

   // Index of the next frame byte: the prefix after the dummy byte, then one on.
   assign cidx = (phase_ff == PH_CMD) ? count_ff[2:0] + 3'd1 : 3'd0;

   // Command frame byte for the next index.
   always_comb begin
      case (cidx)
         3'd0:    cbyte = CMD_PREFIX | {2'b00, cmd_ff};
         3'd1:    cbyte = arg_ff[31:24];
         3'd2:    cbyte = arg_ff[23:16];
         3'd3:    cbyte = arg_ff[15:8];
         3'd4:    cbyte = arg_ff[7:0];
         default: cbyte = CRC_STOP | crc_ff;
      endcase
   end

   // Next phase, counters and result for this item.
   always_comb begin
      logic post, miss;
      post     = 1'b0;
      miss     = 1'b0;
      phase_in = phase_ff;
      count_in = count_ff;
      poll_in  = poll_ff;
      stat_in  = stat_ff;
      res      = '0;
      if (in_item.func == FUNC_START) begin
         stat_in  = ST_OK;
         count_in = '0;
         poll_in  = '0;
         phase_in = PH_DUMMY;
         res.tx_valid = 1'b1;
         res.tx_byte  = BYTE_IDLE;
      end else begin
         case (phase_ff)
            PH_DUMMY: begin
               count_in = '0;
               phase_in = PH_CMD;
               res.tx_valid = 1'b1; res.tx_byte = cbyte; res.cs_active = 1'b1;
            end
            PH_CMD: begin
               if (count_ff >= 10'd5) begin
                  poll_in  = '0;
                  phase_in = PH_POLL;
                  res.tx_valid = 1'b1; res.tx_byte = BYTE_IDLE; res.cs_active = 1'b1;
               end else begin
                  count_in = count_ff + 10'd1;
                  res.tx_valid = 1'b1; res.tx_byte = cbyte; res.cs_active = 1'b1;
               end
            end
            PH_POLL: begin
               if (rx[7]) begin
                  miss = 1'b1;
               end else begin
                  res.r1_valid = 1'b1;
                  res.r1_code  = rx;
                  if (blk_ff) begin
                     if (rx != 8'd0) begin
                        stat_in = ST_CARD_ERR;
                        post    = 1'b1;
                     end else begin
                        poll_in  = '0;
                        phase_in = PH_TOKEN;
                        res.tx_valid = 1'b1; res.tx_byte = BYTE_IDLE;
                        res.cs_active = 1'b1;
                     end
                  end else if (rlen_ff != 3'd0) begin
                     count_in = '0;
                     phase_in = PH_RESP;
                     res.tx_valid = 1'b1; res.tx_byte = BYTE_IDLE; res.cs_active = 1'b1;
                  end else begin
                     post = 1'b1;
                  end
               end
            end
            PH_RESP: begin
               res.data_valid = 1'b1;
               res.data_byte  = rx;
               count_in = count_ff + 10'd1;
               if (count_in >= {7'd0, rlen_ff}) post = 1'b1;
               else begin
                  res.tx_valid = 1'b1; res.tx_byte = BYTE_IDLE; res.cs_active = 1'b1;
               end
            end
            PH_TOKEN: begin
               if (rx == BYTE_TOKEN) begin
                  count_in = '0;
                  phase_in = PH_BLOCK;
                  res.tx_valid = 1'b1; res.tx_byte = BYTE_IDLE; res.cs_active = 1'b1;
               end else begin
                  miss = 1'b1;
               end
            end
            PH_BLOCK: begin
               res.data_valid = 1'b1;
               res.data_byte  = rx;
               if (count_ff >= BLOCK_LAST) post = 1'b1;
               else begin
                  count_in = count_ff + 10'd1;
                  res.tx_valid = 1'b1; res.tx_byte = BYTE_IDLE; res.cs_active = 1'b1;
               end
            end
            PH_POST: begin
               if (count_ff >= {2'd0, post_len}) begin
                  res.done_res = 1'b1;
                  res.status   = stat_ff;
                  phase_in = PH_IDLE;
                  count_in = '0;
               end else begin
                  count_in = count_ff + 10'd1;
                  res.tx_valid = 1'b1; res.tx_byte = BYTE_IDLE;
               end
            end
            default: phase_in = PH_IDLE;
         endcase
         // A failed poll byte counts towards the timeout.
         if (miss) begin
            poll_in = poll_inc;
            if (poll_limit != 16'd0 && poll_inc >= poll_limit) begin
               stat_in = ST_TIMEOUT;
               post    = 1'b1;
            end else begin
               res.tx_valid = 1'b1; res.tx_byte = BYTE_IDLE; res.cs_active = 1'b1;
            end
         end
         // Chip select release: postamble or immediate completion.
         if (post) begin
            if (post_len == 8'd0) begin
               res.done_res = 1'b1;
               res.status   = stat_in;
               phase_in = PH_IDLE;
               count_in = '0;
            end else begin
               res.tx_valid = 1'b1; res.tx_byte = BYTE_IDLE; res.cs_active = 1'b0;
               count_in = 10'd1;
               phase_in = PH_POST;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
         poll_ff  <= '0;
         stat_ff  <= ST_OK;
         arg_ff   <= '0;
         cmd_ff   <= '0;
         crc_ff   <= '0;
         rlen_ff  <= '0;
         blk_ff   <= 1'b0;
      end else if (take) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         poll_ff  <= poll_in;
         stat_ff  <= stat_in;
         if (in_item.func == FUNC_START) begin
            arg_ff  <= in_item.cmd_arg;
            cmd_ff  <= in_item.cmd_index;
            crc_ff  <= in_item.cmd_crc;
            rlen_ff <= in_item.resp_len;
            blk_ff  <= in_item.block_read;
         end
      end
   end
endmodule

// File: rtl/sd_spi_command_engine.sv
// Top level of the SD SPI command engine: request queue, sequencer, result queue.
// Depends on sdspi_pkg, sdspi_queue and sdspi_sequencer.
//
// Usage: each request beat is either a start (func 0, carrying the command) or
// the byte received in the previous SPI exchange (func 1). Every request beat
// yields exactly one response beat naming the next byte to exchange, chip
// select, any R1, response or block byte, and completion with status.
// Requests are pushed with req_push while req_full is low; responses are
// taken with rsp_pop while rsp_empty is low. Registers are written through
// csr_write/csr_index/csr_data while the engine is idle.
// A request pushed into the request queue is taken by the sequencer once the
// result queue has room; its response enters the result queue in that same cycle.
// Throughput: one beat per cycle while the result queue has room, handled by
// the phase machine between the two-entry queues.
// Reset clears the queues, returns the phase to idle and restores
// postamble length 10 and an unlimited poll limit. When the consumer stalls,
// the result queue fills, then the request queue, and req_full rises.
module sd_spi_command_engine #(
   parameter int BLOCK_BYTES = 512
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  sdspi_pkg::req_type req_data,
   output logic               req_full,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output sdspi_pkg::rsp_type rsp_data,
   input  logic               csr_write,
   input  logic               csr_index,
   input  logic [15:0]        csr_data
);
   import sdspi_pkg::*;

   logic [7:0]  post_len_ff;
   logic [15:0] poll_lim_ff;
   logic        q_empty, q_pop, r_full;
   req_type     q_item;
   rsp_type     r_item;
   logic        s_ready, s_valid;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         post_len_ff <= 8'd10;
         poll_lim_ff <= 16'd0;
      end else if (csr_write) begin
         if (csr_index == 1'(CSR_POST_LEN)) post_len_ff <= csr_data[7:0];
         else if (csr_index == 1'(CSR_POLL_LIM)) poll_lim_ff <= csr_data;
      end
   end

   sdspi_queue #(.WIDTH($bits(req_type))) u_req_q (
      .clock, .reset, .push(req_push), .push_data(req_data), .full(req_full),
      .pop(q_pop), .pop_data(q_item), .empty(q_empty)
   );

   assign q_pop = s_ready;

   sdspi_sequencer #(.BLOCK_BYTES(BLOCK_BYTES)) u_seq (
      .clock, .reset, .in_valid(!q_empty), .in_ready(s_ready), .in_item(q_item),
      .out_valid(s_valid), .out_ready(!r_full), .out_item(r_item),
      .post_len(post_len_ff), .poll_limit(poll_lim_ff)
   );

   sdspi_queue #(.WIDTH($bits(rsp_type))) u_rsp_q (
      .clock, .reset, .push(s_valid), .push_data(r_item), .full(r_full),
      .pop(rsp_pop), .pop_data(rsp_data), .empty(rsp_empty)
   );
endmodule

// File: rtl/sdspi_checker.sv
// Port-level checker for the SD SPI command engine, bound to the top level.
// Depends on sdspi_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sdspi_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_push,
   input logic               req_full,
   input logic               rsp_empty,
   input logic               rsp_pop,
   input sdspi_pkg::rsp_type rsp_data
);
   import sdspi_pkg::*;

   // A held result stays put while it waits.
   `ASSERT_CLK(a_hold, clock, reset, (!rsp_empty && !rsp_pop) |=> $stable(rsp_data))
   // Status is never the unused code.
   `ASSERT_CLK(a_status, clock, reset, !rsp_empty |-> rsp_data.status != 2'd3)
   // A completion carries no byte to send.
   `ASSERT_CLK(a_done, clock, reset, (!rsp_empty && rsp_data.done_res) |-> !rsp_data.tx_valid)
   // A request accepted into an empty result path is offered after passing the request and result queues.
   `ASSERT_CLK(a_lat, clock, reset,
      (req_push && !req_full && rsp_empty && $past(rsp_empty)) |-> ##2 !rsp_empty)
endmodule

bind sd_spi_command_engine sdspi_checker u_chk (.*);

// File: bench/tb_sd_spi_command_engine.sv
// Self-checking bench for the SD SPI command engine: predicts every response beat.
// Depends on sdspi_pkg and the sd_spi_command_engine RTL only.
module tb_sd_spi_command_engine;
   import sdspi_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BLK = 512;
   localparam int LATENCY = 3;
   localparam int WATCHDOG_LIMIT = 20000;

   logic clock;
   logic reset;
   logic req_push;
   req_type req_data;
   logic req_full;
   logic rsp_empty;
   logic rsp_pop;
   rsp_type rsp_data;
   logic csr_write;
   logic csr_index;
   logic [15:0] csr_data;

   sd_spi_command_engine #(.BLOCK_BYTES(BLK)) dut (
      .clock(clock), .reset(reset), .req_push(req_push), .req_data(req_data),
      .req_full(req_full), .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_data(rsp_data), .csr_write(csr_write), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // Pending request beats; a hold marker pauses the sender until drained.
   req_type pending_beats[$];
   bit pending_hold[$];
   rsp_type expected_rsp[$];
   int error_count = 0;
   int idle_cycles = 0;
   bit stim_done = 0;

   // Shadow of the engine's registers and state.
   logic [7:0] post_len;
   logic [15:0] poll_lim;
   phase_type ph;
   logic [9:0] bcount;
   logic [15:0] pcount;
   logic [31:0] h_arg;
   logic [5:0] h_cmd;
   logic [7:0] h_crc;
   logic [2:0] h_rlen;
   logic h_blk;
   logic [1:0] h_status;

   // Shadow of the phase the card model is in, for well-formed stimulus.
   phase_type gen_ph;

   function automatic void emit_byte(inout rsp_type r, input logic [7:0] b, input logic cs);
      r.tx_valid = 1'b1;
      r.tx_byte = b;
      r.cs_active = cs;
   endfunction

   function automatic void start_postamble(inout rsp_type r);
      if (post_len == 0) begin
         r.done_res = 1'b1;
         r.status = h_status;
         ph = PH_IDLE;
         bcount = '0;
      end else begin
         emit_byte(r, BYTE_IDLE, 1'b0);
         bcount = 10'd1;
         ph = PH_POST;
      end
   endfunction

   function automatic void missed_poll(inout rsp_type r);
      pcount = pcount + 16'd1;
      if (poll_lim != 0 && pcount >= poll_lim) begin
         h_status = ST_TIMEOUT;
         start_postamble(r);
      end else begin
         emit_byte(r, BYTE_IDLE, 1'b1);
      end
   endfunction

   function automatic logic [7:0] frame_byte(input int i);
      case (i)
         0: frame_byte = CMD_PREFIX | {2'b00, h_cmd};
         1: frame_byte = h_arg[31:24];
         2: frame_byte = h_arg[23:16];
         3: frame_byte = h_arg[15:8];
         4: frame_byte = h_arg[7:0];
         default: frame_byte = CRC_STOP | h_crc;
      endcase
   endfunction

   // Advance the shadow engine by one request beat and return its response.
   function automatic rsp_type predict_exchange(input req_type q);
      rsp_type r;
      r = '0;
      if (q.func == FUNC_START) begin
         h_cmd = q.cmd_index;
         h_arg = q.cmd_arg;
         h_crc = q.cmd_crc;
         h_rlen = q.resp_len;
         h_blk = q.block_read;
         h_status = ST_OK;
         bcount = '0;
         pcount = '0;
         ph = PH_DUMMY;
         emit_byte(r, BYTE_IDLE, 1'b0);
         return r;
      end
      case (ph)
         PH_DUMMY: begin
            bcount = '0;
            ph = PH_CMD;
            emit_byte(r, frame_byte(0), 1'b1);
         end
         PH_CMD: begin
            if (bcount >= 5) begin
               pcount = '0;
               ph = PH_POLL;
               emit_byte(r, BYTE_IDLE, 1'b1);
            end else begin
               bcount = bcount + 10'd1;
               emit_byte(r, frame_byte(int'(bcount)), 1'b1);
            end
         end
         PH_POLL: begin
            if (q.rx_byte[7]) begin
               missed_poll(r);
            end else begin
               r.r1_valid = 1'b1;
               r.r1_code = q.rx_byte;
               if (h_blk) begin
                  if (q.rx_byte != 0) begin
                     h_status = ST_CARD_ERR;
                     start_postamble(r);
                  end else begin
                     pcount = '0;
                     ph = PH_TOKEN;
                     emit_byte(r, BYTE_IDLE, 1'b1);
                  end
               end else if (h_rlen != 0) begin
                  bcount = '0;
                  ph = PH_RESP;
                  emit_byte(r, BYTE_IDLE, 1'b1);
               end else begin
                  start_postamble(r);
               end
            end
         end
         PH_RESP: begin
            r.data_valid = 1'b1;
            r.data_byte = q.rx_byte;
            bcount = bcount + 10'd1;
            if (bcount >= h_rlen) start_postamble(r);
            else emit_byte(r, BYTE_IDLE, 1'b1);
         end
         PH_TOKEN: begin
            if (q.rx_byte == BYTE_TOKEN) begin
               bcount = '0;
               ph = PH_BLOCK;
               emit_byte(r, BYTE_IDLE, 1'b1);
            end else begin
               missed_poll(r);
            end
         end
         PH_BLOCK: begin
            r.data_valid = 1'b1;
            r.data_byte = q.rx_byte;
            if (int'(bcount) + 1 >= BLK) begin
               start_postamble(r);
            end else begin
               bcount = bcount + 10'd1;
               emit_byte(r, BYTE_IDLE, 1'b1);
            end
         end
         PH_POST: begin
            if (bcount >= post_len) begin
               r.done_res = 1'b1;
               r.status = h_status;
               ph = PH_IDLE;
               bcount = '0;
            end else begin
               bcount = bcount + 10'd1;
               emit_byte(r, BYTE_IDLE, 1'b0);
            end
         end
         default: ph = PH_IDLE;
      endcase
      return r;
   endfunction

   // Clock.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int pick_gap();
      int c;
      c = $urandom_range(0, 99);
      if (c < 55) return 0;
      if (c < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // Driver: push pending beats with random gaps, predicting on acceptance.
   int send_gap = 0;
   bit bursty = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            expected_rsp.push_back(predict_exchange(req_data));
            void'(pending_beats.pop_front());
            void'(pending_hold.pop_front());
            send_gap = bursty ? 0 : pick_gap();
            if ($urandom_range(0, 199) == 0) bursty = !bursty;
         end
         if (!(req_push && req_full)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_push <= 1'b0;
            end else if (pending_beats.size() != 0 &&
                         !(pending_hold[0] && expected_rsp.size() != 0)) begin
               req_push <= 1'b1;
               req_data <= pending_beats[0];
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each popped beat against the oldest expectation.
   int pop_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_rsp.size() == 0) begin
               $error("response beat with nothing expected: %h", rsp_data);
               error_count++;
            end else begin
               rsp_type e;
               e = expected_rsp.pop_front();
               if (rsp_data.tx_valid !== e.tx_valid) begin
                  $error("tx_valid: expected %0d, got %0d", e.tx_valid, rsp_data.tx_valid);
                  error_count++;
               end
               if (rsp_data.tx_byte !== e.tx_byte) begin
                  $error("tx_byte: expected %h, got %h", e.tx_byte, rsp_data.tx_byte);
                  error_count++;
               end
               if (rsp_data.cs_active !== e.cs_active) begin
                  $error("cs_active: expected %0d, got %0d", e.cs_active, rsp_data.cs_active);
                  error_count++;
               end
               if (rsp_data.data_valid !== e.data_valid) begin
                  $error("data_valid: expected %0d, got %0d", e.data_valid,
                         rsp_data.data_valid);
                  error_count++;
               end
               if (rsp_data.data_byte !== e.data_byte) begin
                  $error("data_byte: expected %h, got %h", e.data_byte, rsp_data.data_byte);
                  error_count++;
               end
               if (rsp_data.r1_valid !== e.r1_valid) begin
                  $error("r1_valid: expected %0d, got %0d", e.r1_valid, rsp_data.r1_valid);
                  error_count++;
               end
               if (rsp_data.r1_code !== e.r1_code) begin
                  $error("r1_code: expected %h, got %h", e.r1_code, rsp_data.r1_code);
                  error_count++;
               end
               if (rsp_data.done_res !== e.done_res) begin
                  $error("done_res: expected %0d, got %0d", e.done_res, rsp_data.done_res);
                  error_count++;
               end
               if (rsp_data.status !== e.status) begin
                  $error("status: expected %0d, got %0d", e.status, rsp_data.status);
                  error_count++;
               end
            end
         end
         if (pop_gap > 0) begin
            pop_gap--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
            pop_gap = bursty ? 0 : pick_gap();
         end
      end
   end

   // Watchdog: count cycles with no beat accepted on either side.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_sd_spi_command_engine: errors");
            $finish;
         end
      end
   end

   // Stimulus construction.
   function automatic req_type start_beat(input logic [5:0] c, input logic [31:0] a,
                                          input logic [7:0] k, input logic [2:0] rl,
                                          input logic blk);
      req_type q;
      q = '0;
      q.func = FUNC_START;
      q.cmd_index = c;
      q.cmd_arg = a;
      q.cmd_crc = k;
      q.resp_len = rl;
      q.block_read = blk;
      q.rx_byte = 8'($urandom());
      return q;
   endfunction

   function automatic req_type rx_beat(input logic [7:0] b);
      req_type q;
      q = req_type'($bits(req_type)'({$urandom(), $urandom()}));
      q.func = ~FUNC_START;
      q.rx_byte = b;
      return q;
   endfunction

   task automatic queue_beat(input req_type q, input bit hold = 0);
      pending_beats.push_back(q);
      pending_hold.push_back(hold);
   endtask

   // One full command with chosen R1 behaviour; block mode is kept rare.
   task automatic queue_command(input logic [5:0] c, input logic [31:0] a, input logic [7:0] k,
                                input logic [2:0] rl, input logic blk, input int misses,
                                input logic [7:0] r1, input int tok_misses,
                                input int post, input bit hold = 0);
      queue_beat(start_beat(c, a, k, rl, blk), hold);
      repeat (7) queue_beat(rx_beat(8'($urandom())));
      repeat (misses) queue_beat(rx_beat(8'h80 | 8'($urandom())));
      queue_beat(rx_beat(r1));
      if (blk && r1 == 0) begin
         repeat (tok_misses) begin
            logic [7:0] t;
            t = 8'($urandom());
            if (t == BYTE_TOKEN) t = 8'h00;
            queue_beat(rx_beat(t));
         end
         queue_beat(rx_beat(BYTE_TOKEN));
         repeat (BLK) queue_beat(rx_beat(8'($urandom())));
      end else if (!blk) begin
         repeat (rl) queue_beat(rx_beat(8'($urandom())));
      end
      repeat (post + 1) queue_beat(rx_beat(8'($urandom())));
   endtask

   task automatic wait_drained();
      while (pending_beats.size() != 0 || expected_rsp.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [15:0] v);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == 1'(CSR_POST_LEN)) post_len = v[7:0];
      else poll_lim = v;
   endtask

   initial begin
      int settings_post[4] = '{10, 0, 255, 3};
      int settings_poll[4] = '{0, 1, 65535, 4};
      int per_setting[4] = '{6, 6, 1, 6};
      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      rsp_pop = 1'b0;
      csr_write = 1'b0;
      csr_index = 1'b0;
      csr_data = '0;
      post_len = 8'd10;
      poll_lim = 16'd0;
      ph = PH_IDLE;
      bcount = 0; pcount = 0; h_arg = 0; h_cmd = 0; h_crc = 0;
      h_rlen = 0; h_blk = 0; h_status = ST_OK;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: idle receive, extremes, block read, card error, abandon.
      queue_beat(rx_beat(8'hFF));
      queue_command(6'd0, 32'h0, 8'h00, 3'd0, 1'b0, 0, 8'h00, 0, 10);
      queue_command(6'd63, 32'hFFFF_FFFF, 8'hFF, 3'd7, 1'b0, 2, 8'h7F, 0, 10);
      queue_command(6'd17, 32'h1234_5678, 8'hA5, 3'd4, 1'b1, 1, 8'h00, 3, 10, 1'b1);
      queue_command(6'd17, 32'h0000_0001, 8'h3C, 3'd2, 1'b1, 0, 8'h05, 0, 10);
      queue_beat(start_beat(6'd8, 32'h1AA, 8'h87, 3'd4, 1'b0));
      queue_beat(rx_beat(8'h00));
      queue_beat(rx_beat(8'h00));
      wait_drained();

      for (int s = 0; s < 4; s++) begin
         write_reg(1'(CSR_POST_LEN), 16'(settings_post[s]));
         write_reg(1'(CSR_POLL_LIM), 16'(settings_poll[s]));
         for (int n = 0; n < per_setting[s]; n++) begin
            int kind;
            int misses;
            logic [7:0] r1;
            kind = $urandom_range(0, 99);
            misses = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
            r1 = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 127)) : 8'h00;
            if (kind < 6) begin
               queue_command(6'($urandom()), $urandom(), 8'($urandom()), 3'($urandom()),
                             1'b1, misses, r1, $urandom_range(0, 4), settings_post[s]);
            end else if (kind < 14) begin
               // Noise and broken sequences, including restarts mid-command.
               queue_beat(start_beat(6'($urandom()), $urandom(), 8'($urandom()),
                                     3'($urandom()), 1'($urandom())));
               repeat ($urandom_range(0, 12)) queue_beat(rx_beat(8'($urandom())));
            end else begin
               queue_command(6'($urandom()), $urandom(), 8'($urandom()), 3'($urandom()),
                             1'b0, misses, r1, 0, settings_post[s], n == 3);
            end
         end
         // Finish any abandoned command before touching registers.
         queue_command(6'd1, 32'h0, 8'h95, 3'd0, 1'b0, 0, 8'h01, 0, settings_post[s]);
         wait_drained();
      end

      stim_done = 1;
      if (error_count == 0) $display("tb_sd_spi_command_engine: clean");
      else $display("tb_sd_spi_command_engine: errors");
      $finish;
   end

endmodule
